// ===== sv/ultrasonic_echo_range_averager_defines.svh =====
// Assertion macros for the ultrasonic echo range averager.
// Included by the modules that carry concurrent assertions; no dependencies.
`ifndef ULTRASONIC_ECHO_RANGE_AVERAGER_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGE_AVERAGER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UERA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("Same-cycle check failed.");

// Next-cycle implication, disabled while reset is asserted.
`define UERA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("Next-cycle check failed.");

`endif

// ===== sv/uera_pkg.sv =====
// Shared types and constants for the ultrasonic echo range averager.
// Used by every module of the block; depends on nothing.
package uera_pkg;

  localparam int DIST_W    = 12;
  localparam int CNT_OUT_W = 5;
  localparam int CAP_W     = 16;
  localparam int THR_W     = 8;
  localparam int WS_W      = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 12;
  localparam int STEP_W    = 4;

  // Division by 17 as a multiplication: 61681 * 17 = 2^20 + 1, exact for 16-bit inputs.
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 20;
  localparam logic [RECIP_W-1:0] RECIP_17 = 17'd61681;
  localparam int PROD_W      = CAP_W + RECIP_W;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_MIN_RANGE   = 3'd0;
  localparam cfg_idx_t CFG_MAX_RANGE   = 3'd1;
  localparam cfg_idx_t CFG_WINDOW_SIZE = 3'd2;
  localparam cfg_idx_t CFG_BLANK_THR   = 3'd3;
  localparam cfg_idx_t CFG_TIMEOUT_THR = 3'd4;

  localparam logic [DIST_W-1:0] RST_MIN_RANGE   = 12'd450;
  localparam logic [DIST_W-1:0] RST_MAX_RANGE   = 12'd800;
  localparam logic [WS_W-1:0]   RST_WINDOW_SIZE = 5'd1;
  localparam logic [THR_W-1:0]  RST_BLANK_THR   = 8'h1D;
  localparam logic [THR_W-1:0]  RST_TIMEOUT_THR = 8'h58;

  localparam logic MODE_FIRE = 1'b0;

  typedef struct packed {
    logic              mode;
    logic [THR_W-1:0]  timer_high;
    logic              echo_edge;
    logic [CAP_W-1:0]  capture_value;
  } in_t;

  typedef struct packed {
    logic [DIST_W-1:0]    distance;
    logic [CNT_OUT_W-1:0] valid_count;
    logic                 timed_out;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STORE,
    ST_SCAN,
    ST_DIV,
    ST_WAIT_DIV,
    ST_DONE
  } state_t;

endpackage

// ===== sv/ultrasonic_echo_range_averager.sv =====
// Ultrasonic echo ranging with a moving-average window: top level, control and configuration.
// Instantiates uera_store and uera_div; uses uera_pkg and the assertion macros.
//
// A fire or a poll that produces no result is taken while the block stays idle. A poll that
// stores a sample holds the block busy until its result is loaded. In order, it stores the
// sample, reads the n entries of the window back through the registered memory port, where
// n is the effective window size, starts the divider, waits for the bit-serial divider,
// loads the output register and returns to idle, where the next item is taken. When no
// entry lies inside the limits the divider is skipped. A new item is accepted while the
// previous result still waits on the output register, but a result that finds that
// register still full holds the block in its last step until the waiting transfer
// completes. Writing window_size empties the window at once through per-entry valid bits,
// so the block needs no clearing pass after reset or after that write.
`include "ultrasonic_echo_range_averager_defines.svh"

module ultrasonic_echo_range_averager #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  uera_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output uera_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  uera_pkg::cfg_idx_t              cfg_index,
  input  logic [uera_pkg::CFG_DAT_W-1:0]  cfg_data
);

  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int NW = $clog2(WINDOW_DEPTH + 1);
  localparam int SW = uera_pkg::DIST_W + NW;
  localparam int DW = uera_pkg::DIST_W;

  uera_pkg::state_t state_r, state_nxt;

  logic [DW-1:0]                 min_r, min_nxt;
  logic [DW-1:0]                 max_r, max_nxt;
  logic [uera_pkg::WS_W-1:0]     ws_r, ws_nxt;
  logic [uera_pkg::THR_W-1:0]    blank_r, blank_nxt;
  logic [uera_pkg::THR_W-1:0]    tmo_r, tmo_nxt;

  logic                          waiting_r, waiting_nxt;
  logic                          armed_r, armed_nxt;
  logic                          armed_now;
  logic [AW-1:0]                 slot_r, slot_nxt;
  logic [AW-1:0]                 slot_use;
  logic [NW-1:0]                 slot_inc;
  logic [NW-1:0]                 eff_n;

  logic [uera_pkg::PROD_W-1:0]   prod_r, prod_nxt;
  logic                          to_r, to_nxt;
  logic [NW-1:0]                 idx_r, idx_nxt;
  logic                          pend_r, pend_nxt;
  logic [SW-1:0]                 sum_r, sum_nxt;
  logic [NW-1:0]                 cnt_r, cnt_nxt;
  logic [DW-1:0]                 dist_r, dist_nxt;

  logic                          out_valid_r, out_valid_nxt;
  uera_pkg::out_t                out_data_r, out_data_nxt;

  logic                          cfg_fire;
  logic                          mem_clear;
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [DW-1:0]                 mem_wdata;
  logic [AW-1:0]                 mem_raddr;
  logic [DW-1:0]                 mem_rdata;
  logic                          div_start;
  logic                          div_done;
  logic [DW-1:0]                 div_quot;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_stall  = (state_r != uera_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign mem_raddr = idx_r[AW-1:0];

  always_comb begin
    if (ws_r == '0) begin
      eff_n = NW'(1);
    end else if (32'(ws_r) > WINDOW_DEPTH) begin
      eff_n = NW'(WINDOW_DEPTH);
    end else begin
      eff_n = NW'(ws_r);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    ws_nxt        = ws_r;
    blank_nxt     = blank_r;
    tmo_nxt       = tmo_r;
    waiting_nxt   = waiting_r;
    armed_nxt     = armed_r;
    slot_nxt      = slot_r;
    prod_nxt      = prod_r;
    to_nxt        = to_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    dist_nxt      = dist_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_clear     = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = slot_r;
    mem_wdata     = '0;
    div_start     = 1'b0;
    armed_now     = armed_r || (in_data.timer_high > blank_r);
    slot_use      = (NW'(slot_r) >= eff_n) ? '0 : slot_r;
    slot_inc      = NW'(slot_use) + 1'b1;

    if (cfg_fire) begin
      case (cfg_index)
        uera_pkg::CFG_MIN_RANGE:   min_nxt   = cfg_data[DW-1:0];
        uera_pkg::CFG_MAX_RANGE:   max_nxt   = cfg_data[DW-1:0];
        uera_pkg::CFG_WINDOW_SIZE: begin
          ws_nxt    = cfg_data[uera_pkg::WS_W-1:0];
          mem_clear = 1'b1;
        end
        uera_pkg::CFG_BLANK_THR:   blank_nxt = cfg_data[uera_pkg::THR_W-1:0];
        uera_pkg::CFG_TIMEOUT_THR: tmo_nxt   = cfg_data[uera_pkg::THR_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      uera_pkg::ST_IDLE: begin
        if (in_valid) begin
          prod_nxt = uera_pkg::PROD_W'(in_data.capture_value) *
                     uera_pkg::PROD_W'(uera_pkg::RECIP_17);
          if (in_data.mode == uera_pkg::MODE_FIRE) begin
            waiting_nxt = 1'b1;
            armed_nxt   = 1'b0;
          end else if (waiting_r) begin
            armed_nxt = armed_now;
            if (in_data.timer_high > tmo_r) begin
              to_nxt    = 1'b1;
              state_nxt = uera_pkg::ST_STORE;
            end else if (in_data.echo_edge && armed_now) begin
              to_nxt    = 1'b0;
              state_nxt = uera_pkg::ST_STORE;
            end
          end
        end
      end
      uera_pkg::ST_STORE: begin
        mem_we      = 1'b1;
        mem_waddr   = slot_use;
        mem_wdata   = to_r ? '0 : prod_r[uera_pkg::RECIP_SHIFT +: DW];
        slot_nxt    = (slot_inc >= eff_n) ? '0 : AW'(slot_inc);
        waiting_nxt = 1'b0;
        armed_nxt   = 1'b0;
        idx_nxt     = '0;
        pend_nxt    = 1'b0;
        sum_nxt     = '0;
        cnt_nxt     = '0;
        state_nxt   = uera_pkg::ST_SCAN;
      end
      uera_pkg::ST_SCAN: begin
        if (pend_r && (mem_rdata >= min_r) && (mem_rdata <= max_r)) begin
          sum_nxt = sum_r + SW'(mem_rdata);
          cnt_nxt = cnt_r + 1'b1;
        end
        if (idx_r < eff_n) begin
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = uera_pkg::ST_DIV;
          end
        end
      end
      uera_pkg::ST_DIV: begin
        if (cnt_r == '0) begin
          dist_nxt  = '0;
          state_nxt = uera_pkg::ST_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = uera_pkg::ST_WAIT_DIV;
        end
      end
      uera_pkg::ST_WAIT_DIV: begin
        if (div_done) begin
          dist_nxt  = div_quot;
          state_nxt = uera_pkg::ST_DONE;
        end
      end
      uera_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt.distance    = dist_r;
          out_data_nxt.valid_count = uera_pkg::CNT_OUT_W'(cnt_r);
          out_data_nxt.timed_out   = to_r;
          out_valid_nxt            = 1'b1;
          state_nxt                = uera_pkg::ST_IDLE;
        end
      end
      default: state_nxt = uera_pkg::ST_IDLE;
    endcase

    if (cfg_fire && cfg_index == uera_pkg::CFG_WINDOW_SIZE) begin
      slot_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= uera_pkg::ST_IDLE;
      min_r       <= uera_pkg::RST_MIN_RANGE;
      max_r       <= uera_pkg::RST_MAX_RANGE;
      ws_r        <= uera_pkg::RST_WINDOW_SIZE;
      blank_r     <= uera_pkg::RST_BLANK_THR;
      tmo_r       <= uera_pkg::RST_TIMEOUT_THR;
      waiting_r   <= 1'b0;
      armed_r     <= 1'b0;
      slot_r      <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      ws_r        <= ws_nxt;
      blank_r     <= blank_nxt;
      tmo_r       <= tmo_nxt;
      waiting_r   <= waiting_nxt;
      armed_r     <= armed_nxt;
      slot_r      <= slot_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    prod_r     <= prod_nxt;
    to_r       <= to_nxt;
    sum_r      <= sum_nxt;
    cnt_r      <= cnt_nxt;
    dist_r     <= dist_nxt;
    out_data_r <= out_data_nxt;
  end

  uera_store #(
    .DEPTH (WINDOW_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (mem_clear),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  uera_div #(
    .CW (NW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (cnt_r),
    .done     (div_done),
    .quot     (div_quot)
  );

  `UERA_ASSERT_NOW(a_scan_index_bounded, clk, rst_n, state_r == uera_pkg::ST_SCAN, idx_r <= eff_n)
  `UERA_ASSERT_NXT(a_result_loaded, clk, rst_n, state_r == uera_pkg::ST_DONE && (!out_valid_r || !out_stall), out_valid_r)
  `UERA_ASSERT_NXT(a_resize_resets_slot, clk, rst_n, cfg_fire && cfg_index == uera_pkg::CFG_WINDOW_SIZE, slot_r == '0)

endmodule

// ===== sv/uera_store.sv =====
// Sample store: synchronous memory with a registered read port and per-entry valid bits.
// Entries that were never written since the last clear read as zero. Uses uera_pkg.
module uera_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clear,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [uera_pkg::DIST_W-1:0]  wdata,
  input  logic [AW-1:0]                raddr,
  output logic [uera_pkg::DIST_W-1:0]  rdata
);

  logic [uera_pkg::DIST_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]            vld_r;
  logic [uera_pkg::DIST_W-1:0] rd_mem_r;
  logic                        rd_vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_mem_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[raddr];
      if (clear) begin
        vld_r <= '0;
      end else if (we) begin
        vld_r[waddr] <= 1'b1;
      end
    end
  end

  assign rdata = rd_vld_r ? rd_mem_r : '0;

endmodule

// ===== sv/uera_div.sv =====
// Restoring divider producing a 12-bit quotient, one bit per cycle.
// The quotient is known to fit in 12 bits. Uses uera_pkg and the assertion macros.
`include "ultrasonic_echo_range_averager_defines.svh"

module uera_div #(
  parameter int CW = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [CW+uera_pkg::DIST_W-1:0] dividend,
  input  logic [CW-1:0]                  divisor,
  output logic                           done,
  output logic [uera_pkg::DIST_W-1:0]    quot
);

  localparam int QW = uera_pkg::DIST_W;

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [uera_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic [CW-1:0]                 rem_r, rem_nxt;
  logic [CW-1:0]                 dsr_r, dsr_nxt;
  logic [QW-1:0]                 shf_r, shf_nxt;
  logic [CW:0]                   trial;
  logic                          ge;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    shf_nxt  = shf_r;
    trial    = {rem_r, shf_r[QW-1]};
    ge       = trial >= {1'b0, dsr_r};
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = dividend[CW+QW-1:QW];
      dsr_nxt  = divisor;
      shf_nxt  = dividend[QW-1:0];
    end else if (busy_r) begin
      rem_nxt  = ge ? CW'(trial - {1'b0, dsr_r}) : CW'(trial);
      shf_nxt  = {shf_r[QW-2:0], ge};
      step_nxt = step_r + 1'b1;
      if (step_r == uera_pkg::STEP_W'(QW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
    shf_r  <= shf_nxt;
  end

  assign done = done_r;
  assign quot = shf_r;

  `UERA_ASSERT_NOW(a_rem_below_divisor, clk, rst_n, busy_r, rem_r < dsr_r)
  `UERA_ASSERT_NXT(a_start_goes_busy, clk, rst_n, start && !busy_r, busy_r)

endmodule
